@@ rtl/core/kwfc_pkg.sv @@
// Shared types, constants and command codes for the keyword frequency counter.
`timescale 1ns / 1ps
package kwfc_pkg;

  localparam int unsigned KEYWORD_SLOTS_DEF = 16;
  localparam int unsigned MAX_WORD_LEN_DEF  = 32;
  localparam int unsigned COUNT_WIDTH_DEF   = 32;

  localparam int unsigned COMMAND_W  = 3;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned POSITION_W = 5;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned COUNT_OUT_W = 32;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_KEY_BYTE  = 3'd0,
    CMD_KEY_LEN   = 3'd1,
    CMD_TEXT_BYTE = 3'd2,
    CMD_TEXT_END  = 3'd3,
    CMD_READ      = 3'd4,
    CMD_CLEAR     = 3'd5
  } cmd_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the input word
    logic exec;      // run the latched word (one cycle)
    logic sweep;     // step one slot of the word-end compare
    logic finish;    // close the word: clear its length and overflow flag
  } dp_ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic word_end;  // latched word ends a word that needs a compare
    logic last_slot; // sweep is at the last slot or matches this slot
  } dp_stat_t;

  function automatic logic is_space(input logic [VALUE_W-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

@@ rtl/core/kwfc_ctrl.sv @@
// Controller state machine: sequences capture, execute, slot sweep and output.
`timescale 1ns / 1ps
module kwfc_ctrl
  import kwfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic     out_free,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl,
  output logic     busy,
  output logic     out_load
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SWEEP, S_OUT} state_t;
  state_t state;

  // Decode commands from state
  always_comb begin
    ctrl = '0;
    ctrl.capture = in_fire;
    ctrl.exec    = (state == S_EXEC);
    ctrl.sweep   = (state == S_SWEEP);
    ctrl.finish  = (state == S_SWEEP) && stat.last_slot;
  end

  assign busy     = (state != S_IDLE);
  assign out_load = (state == S_OUT) && out_free;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (in_fire) state <= S_EXEC;
        S_EXEC:  state <= stat.word_end ? S_SWEEP : S_OUT;
        S_SWEEP: if (stat.last_slot) state <= S_OUT;
        S_OUT:   if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/kwfc_dp.sv @@
// Datapath: keyword memory, lengths, counters, word buffer and result formation.
`timescale 1ns / 1ps
module kwfc_dp
  import kwfc_pkg::*;
#(
  parameter int unsigned KEYWORD_SLOTS = KEYWORD_SLOTS_DEF,
  parameter int unsigned MAX_WORD_LEN  = MAX_WORD_LEN_DEF,
  parameter int unsigned COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_ctrl_t               ctrl,
  input  logic [COMMAND_W-1:0]   command,
  input  logic [SLOT_W-1:0]      slot,
  input  logic [POSITION_W-1:0]  position,
  input  logic [VALUE_W-1:0]     value,
  output dp_stat_t               stat,
  output logic                   match_found,
  output logic [SLOT_W-1:0]      match_slot,
  output logic [COUNT_OUT_W-1:0] count_value,
  output logic                   long_word
);

  localparam int unsigned SI_W  = (KEYWORD_SLOTS > 1) ? $clog2(KEYWORD_SLOTS) : 1;
  localparam int unsigned BI_W  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Latched input word
  logic [COMMAND_W-1:0]  cmd_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [POSITION_W-1:0] pos_q;
  logic [VALUE_W-1:0]    val_q;

  // Keyword table: one row per slot, all bytes of a row in one word
  logic [MAX_WORD_LEN*VALUE_W-1:0] kw_mem [KEYWORD_SLOTS];
  logic [MAX_WORD_LEN*VALUE_W-1:0] kw_row;
  logic [LEN_W-1:0]       kw_len   [KEYWORD_SLOTS];
  logic [COUNT_WIDTH-1:0] counts   [KEYWORD_SLOTS];
  logic [MAX_WORD_LEN*VALUE_W-1:0] word_buf;
  logic [LEN_W-1:0]       word_len;
  logic                   word_ovf;
  logic [SI_W:0]          scan;
  logic                   matched;

  logic slot_ok, pos_ok, space_in, ends_word;
  logic [SI_W-1:0] slot_i;
  logic [SI_W-1:0] scan_i;
  logic [MAX_WORD_LEN*VALUE_W-1:0] mask;
  logic hit;

  assign slot_ok  = {{(32-SLOT_W){1'b0}}, slot_q} < KEYWORD_SLOTS;
  assign pos_ok   = {{(32-POSITION_W){1'b0}}, pos_q} < MAX_WORD_LEN;
  assign slot_i   = SI_W'(slot_q);
  assign scan_i   = scan[SI_W-1:0];
  assign space_in = is_space(val_q);
  assign ends_word = ((cmd_q == CMD_TEXT_END) || (cmd_q == CMD_TEXT_BYTE && space_in))
                     && !word_ovf && (word_len != '0);
  assign stat.word_end  = ends_word;
  assign stat.last_slot = hit || ({{(31-SI_W){1'b0}}, scan} >= KEYWORD_SLOTS - 1);

  // Mask off bytes beyond the word length for the row compare
  always_comb begin
    for (int b = 0; b < MAX_WORD_LEN; b++)
      mask[b*VALUE_W +: VALUE_W] = (b < int'(word_len)) ? '1 : '0;
  end

  assign hit = ctrl.sweep && !matched && (kw_len[scan_i] == word_len)
               && ((kw_row & mask) == (word_buf & mask));

  // Keyword row write and registered row read for the sweep
  always_ff @(posedge clk) begin
    if (ctrl.exec && cmd_q == CMD_KEY_BYTE && slot_ok && pos_ok)
      kw_mem[slot_i][BI_W'(pos_q)*VALUE_W +: VALUE_W] <= val_q;
    kw_row <= kw_mem[ctrl.sweep ? SI_W'(scan + 1'b1) : '0];
  end

  // Capture input and handle the command
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q <= command; slot_q <= slot; pos_q <= position; val_q <= value;
    end
    if (rst) begin
      word_len <= '0;
      word_ovf <= 1'b0;
      matched  <= 1'b0;
      scan     <= '0;
      for (int s = 0; s < KEYWORD_SLOTS; s++) begin
        kw_len[s] <= '0;
        counts[s] <= '0;
      end
    end else begin
      if (ctrl.exec) begin
        match_found <= 1'b0; match_slot <= '0; count_value <= '0; long_word <= 1'b0;
        scan <= '0; matched <= 1'b0;
        case (cmd_q)
          CMD_KEY_LEN:
            if (slot_ok)
              kw_len[slot_i] <= ({1'b0, val_q} <= 9'(MAX_WORD_LEN)) ? LEN_W'(val_q) : '0;
          CMD_TEXT_BYTE, CMD_TEXT_END:
            if (cmd_q == CMD_TEXT_BYTE && !space_in) begin
              if (word_len < LEN_W'(MAX_WORD_LEN)) begin
                word_buf[BI_W'(word_len)*VALUE_W +: VALUE_W] <= val_q;
                word_len <= word_len + 1'b1;
              end else begin
                word_ovf <= 1'b1;
              end
            end else if (!ends_word) begin
              long_word <= word_ovf;
              word_len  <= '0;
              word_ovf  <= 1'b0;
            end
          CMD_READ: begin
            match_slot  <= slot_q;
            count_value <= slot_ok ? COUNT_OUT_W'(counts[slot_i]) : '0;
          end
          CMD_CLEAR:
            for (int s = 0; s < KEYWORD_SLOTS; s++) counts[s] <= '0;
          default: ;
        endcase
      end
      // Step one slot per cycle; bump the first matching slot
      if (ctrl.sweep) begin
        scan <= scan + 1'b1;
        if (hit) begin
          matched     <= 1'b1;
          match_found <= 1'b1;
          match_slot  <= SLOT_W'(scan_i);
          if (counts[scan_i] != COUNT_MAX) begin
            counts[scan_i] <= counts[scan_i] + 1'b1;
            count_value    <= COUNT_OUT_W'(counts[scan_i] + 1'b1);
          end else begin
            count_value    <= COUNT_OUT_W'(counts[scan_i]);
          end
        end
      end
      if (ctrl.finish) begin
        word_len <= '0;
        word_ovf <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/keyword_frequency_counter.sv @@
// Top level of the keyword frequency counter.
// Usage:
//   s_axis carries one command word per handshake: keyword byte, keyword
//   length, text byte, end of text, read count or clear counts. m_axis
//   returns exactly one result word per command accepted.
//   Keyword bytes and lengths load the table; text bytes build a word, and a
//   whitespace byte or end of text closes it and compares it to the slots in order.
// Sequencing:
//   A command that closes a word walks the keyword table one slot per cycle
//   until the lowest match (all KEYWORD_SLOTS slots when nothing matches);
//   every other command goes straight from execute to output. The next
//   command is taken only after the result of the current one has been
//   loaded into the output register.
//   One command is in flight at a time; s_axis_tready is low while it runs.
// Reset:
//   rst clears all lengths (all slots unused), all counts and the word in
//   progress. Keyword bytes are undefined until written.
// Stall:
//   The result is held in an output register until m_axis_tready. The next
//   command may be taken while that word waits; its own result then holds
//   in the datapath, with s_axis_tready low, until the register frees.
`timescale 1ns / 1ps
module keyword_frequency_counter
  import kwfc_pkg::*;
#(
  parameter int unsigned KEYWORD_SLOTS = KEYWORD_SLOTS_DEF,
  parameter int unsigned MAX_WORD_LEN  = MAX_WORD_LEN_DEF,
  parameter int unsigned COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] command, [6:3] slot, [11:7] position, [19:12] value, [23:20] zero
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] match_found, [4:1] match_slot, [36:5] count_value, [37] long_word,
  // [39:38] zero
  output logic [39:0] m_axis_tdata
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic busy, out_load, in_fire;
  logic                   match_found, long_word;
  logic [SLOT_W-1:0]      match_slot;
  logic [COUNT_OUT_W-1:0] count_value;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  kwfc_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_free(!m_axis_tvalid || m_axis_tready),
    .stat, .ctrl, .busy, .out_load
  );

  kwfc_dp #(
    .KEYWORD_SLOTS(KEYWORD_SLOTS), .MAX_WORD_LEN(MAX_WORD_LEN), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk, .rst, .ctrl,
    .command (s_axis_tdata[2:0]),
    .slot    (s_axis_tdata[6:3]),
    .position(s_axis_tdata[11:7]),
    .value   (s_axis_tdata[19:12]),
    .stat, .match_found, .match_slot, .count_value, .long_word
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {2'b00, long_word, count_value, match_slot, match_found};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ bench/kwfc_checker.sv @@
// Stream monitor, word-count predictor and result comparator for the counter.
`timescale 1ns / 1ps
module kwfc_checker
  import kwfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          fail_count,
  output int          results_owed
);

  // Fields from the highest bit down, matching the result word layout
  typedef struct packed {
    logic        long_word;
    logic [31:0] count;
    logic [3:0]  slot;
    logic        found;
  } tally_t;

  // Shadow copy of the keyword table, the counters and the word in progress
  logic [7:0]  kw_byte [16][32];
  logic [5:0]  kw_len  [16];
  logic [31:0] hits    [16];
  logic [7:0]  word    [32];
  int          word_len;
  logic        word_long;
  tally_t      owed_q[$];

  function automatic logic blank_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Close the current word: compare against the slots in order, lowest match wins
  function automatic tally_t close_word();
    tally_t t;
    logic   same;
    t = '0;
    if (word_long) begin
      t.long_word = 1'b1;
    end else if (word_len != 0) begin
      for (int s = 0; s < 16; s++) begin
        if (kw_len[s] == 0 || kw_len[s] != word_len) continue;
        same = 1'b1;
        for (int i = 0; i < word_len; i++)
          if (kw_byte[s][i] != word[i]) same = 1'b0;
        if (same) begin
          if (hits[s] != '1) hits[s] = hits[s] + 1;
          t.found = 1'b1;
          t.slot  = s[3:0];
          t.count = hits[s];
          break;
        end
      end
    end
    word_len  = 0;
    word_long = 1'b0;
    return t;
  endfunction

  function automatic tally_t count_word(input logic [23:0] w);
    tally_t     t;
    logic [2:0] cmd;
    logic [3:0] slot;
    logic [4:0] pos;
    logic [7:0] val;
    {val, pos, slot, cmd} = w[19:0];
    t = '0;
    case (cmd)
      CMD_KEY_BYTE: kw_byte[slot][pos] = val;
      CMD_KEY_LEN:  kw_len[slot] = (val <= 32) ? val[5:0] : 6'd0;
      CMD_TEXT_BYTE: begin
        if (blank_char(val)) t = close_word();
        else if (word_len < 32) begin
          word[word_len] = val;
          word_len++;
        end else word_long = 1'b1;
      end
      CMD_TEXT_END: t = close_word();
      CMD_READ: begin
        t.slot  = slot;
        t.count = hits[slot];
      end
      CMD_CLEAR: for (int s = 0; s < 16; s++) hits[s] = '0;
      default: ;
    endcase
    return t;
  endfunction

  always @(posedge clk) begin
    tally_t got, want;
    if (rst) begin
      for (int s = 0; s < 16; s++) begin
        kw_len[s] = '0;
        hits[s]   = '0;
      end
      word_len   = 0;
      word_long  = 1'b0;
      fail_count = 0;
      owed_q.delete();
    end else begin
      // Compare the outgoing word before queueing a new prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[37:0];
        if (owed_q.size() == 0) begin
          $error("result word with nothing expected: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          if (got.found !== want.found) begin
            $error("match_found: expected %0d, got %0d", want.found, got.found);
            fail_count++;
          end
          if (got.slot !== want.slot) begin
            $error("match_slot: expected %0d, got %0d", want.slot, got.slot);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $error("count_value: expected %0d, got %0d", want.count, got.count);
            fail_count++;
          end
          if (got.long_word !== want.long_word) begin
            $error("long_word: expected %0d, got %0d", want.long_word,
                   got.long_word);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        owed_q.insert(owed_q.size(), count_word(s_axis_tdata));
    end
    results_owed = owed_q.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Stimulus, clock, reset and verdict for the keyword frequency counter bench.
`timescale 1ns / 1ps
module tb_top
  import kwfc_pkg::*;
;

  // Command codes with no function
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  int          fail_count;
  int          results_owed;

  // Bench copy of the table, used to build matching words and legal lengths
  logic [7:0]  kw_byte [16][32];
  logic [5:0]  kw_len  [16];
  logic [31:0] kw_written [16];
  int          words_sent;
  bit          calm;
  bit          paused;
  int          sink_hold;
  logic [7:0]  blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  always #1 clk = ~clk;

  keyword_frequency_counter i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  kwfc_checker i_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  // Stall the result side at random, drawing a new hold per accepted word
  always @(posedge clk)
    if (m_axis_tvalid && m_axis_tready) sink_hold = calm ? 0 : $urandom_range(0, 14);

  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold--;
    end else m_axis_tready <= 1'b1;
  end

  // Drive one command word after a random gap and hold it until accepted
  task automatic send(input logic [2:0] cmd, input logic [3:0] slot,
                      input logic [4:0] pos, input logic [7:0] val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0, val, pos, slot, cmd};
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    if (cmd == CMD_KEY_BYTE) begin
      kw_byte[slot][pos] = val;
      kw_written[slot][pos] = 1'b1;
    end
    if (cmd == CMD_KEY_LEN) kw_len[slot] = (val <= 32) ? val[5:0] : 6'd0;
  endtask

  // Write a keyword over a small alphabet so text words hit it often
  task automatic load_keyword(input int slot, input int len);
    for (int i = 0; i < len; i++)
      send(CMD_KEY_BYTE, slot[3:0], i[4:0], 8'(8'h61 + $urandom_range(0, 1)));
    send(CMD_KEY_LEN, slot[3:0], 5'($urandom), len[7:0]);
  endtask

  // Length is legal only when every byte below it has been written
  function automatic logic [7:0] legal_length(input logic [3:0] slot,
                                              input logic [7:0] val);
    logic [32:0] need;
    if (val == 0 || val > 32) return val;
    need = (33'd1 << val) - 1;
    return ((kw_written[slot] & need[31:0]) == need[31:0]) ? val : 8'd0;
  endfunction

  // Text word: copy of a slot, short random word, arbitrary bytes, or too long
  task automatic send_word(input int kind);
    int         len;
    int         s;
    logic [7:0] c;
    case (kind)
      0: begin
        s = $urandom_range(0, 15);
        len = int'(kw_len[s]);
        for (int i = 0; i < len; i++)
          send(CMD_TEXT_BYTE, 4'($urandom), 5'($urandom), kw_byte[s][i]);
      end
      1: begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          send(CMD_TEXT_BYTE, 4'($urandom), 5'($urandom),
               8'(8'h61 + $urandom_range(0, 1)));
      end
      2: begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          do c = 8'($urandom); while (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D));
          send(CMD_TEXT_BYTE, 4'($urandom), 5'($urandom), c);
        end
      end
      default: begin
        len = $urandom_range(33, 40);
        for (int i = 0; i < len; i++)
          send(CMD_TEXT_BYTE, 4'($urandom), 5'($urandom), 8'h61);
      end
    endcase
    if ($urandom_range(0, 9) == 0)
      send(CMD_TEXT_END, 4'($urandom), 5'($urandom), 8'($urandom));
    else send(CMD_TEXT_BYTE, 4'($urandom), 5'($urandom), blanks[$urandom_range(0, 5)]);
  endtask

  initial begin
    #2000000;
    $display("** keyword_frequency_counter: FAILED **");
    $finish;
  end

  initial begin
    logic [2:0] cmd;
    logic [7:0] val;
    int         pick;
    for (int s = 0; s < 16; s++) begin
      kw_len[s] = '0;
      kw_written[s] = '0;
    end
    words_sent = 0;
    calm = 1'b0;
    paused = 1'b0;
    sink_hold = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: duplicate keywords, full-length keyword, oversize length,
    // long word, empty word end, unused codes, read and clear
    load_keyword(0, 2);
    load_keyword(3, 2);
    for (int i = 0; i < 2; i++) send(CMD_KEY_BYTE, 4'd3, i[4:0], kw_byte[0][i]);
    load_keyword(15, 32);
    send(CMD_KEY_LEN, 4'd5, 5'd0, 8'd200);
    send(CMD_TEXT_BYTE, 4'd0, 5'd0, kw_byte[0][0]);
    send(CMD_TEXT_BYTE, 4'd0, 5'd0, kw_byte[0][1]);
    send(CMD_TEXT_BYTE, 4'd0, 5'd0, 8'h20);
    send(CMD_TEXT_BYTE, 4'd0, 5'd0, 8'h0D);
    send(CMD_TEXT_END, 4'd0, 5'd0, 8'h00);
    send(CMD_SPARE_A, 4'hF, 5'h1F, 8'hFF);
    send(CMD_SPARE_B, 4'h0, 5'h00, 8'h00);
    send(CMD_READ, 4'd0, 5'd0, 8'd0);
    send(CMD_READ, 4'd15, 5'd0, 8'd0);
    send(CMD_CLEAR, 4'd0, 5'd0, 8'd0);
    send(CMD_READ, 4'd0, 5'd0, 8'd0);
    send_word(3);

    // Random: mostly words with random content, plus loads, reads and noise
    while (words_sent < 950) begin
      // Drain once: drop valid and wait for every owed result
      if (!paused && words_sent > 500) begin
        paused = 1'b1;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        wait (results_owed == 0);
        repeat (25) @(posedge clk);
      end
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      pick = $urandom_range(0, 99);
      if (pick < 70) send_word(pick < 35 ? 0 : (pick < 55 ? 1 : (pick < 67 ? 2 : 3)));
      else if (pick < 78)
        load_keyword($urandom_range(0, 15),
                     $urandom_range(0, 7) == 0 ? 32 : $urandom_range(1, 3));
      else if (pick < 84) send(CMD_READ, 4'($urandom), 5'($urandom), 8'($urandom));
      else if (pick < 86) send(CMD_CLEAR, 4'($urandom), 5'($urandom), 8'($urandom));
      else if (pick < 88) send(CMD_TEXT_END, 4'($urandom), 5'($urandom), 8'($urandom));
      else begin
        cmd = 3'($urandom);
        val = 8'($urandom);
        pick = $urandom_range(0, 15);
        if (cmd == CMD_KEY_LEN) val = legal_length(pick[3:0], val);
        send(cmd, pick[3:0], 5'($urandom), val);
      end
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    wait (results_owed == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("** keyword_frequency_counter: PASSED **");
    else $display("** keyword_frequency_counter: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/kwfc_pkg.sv
rtl/core/kwfc_ctrl.sv
rtl/core/kwfc_dp.sv
rtl/core/keyword_frequency_counter.sv
bench/kwfc_checker.sv
bench/tb_top.sv
